// ----- rtl/sdsi_pkg.sv -----
// Shared constants for the SD SPI init and write sequencer.
`timescale 1ns / 1ps

package sdsi_pkg;

  // Item opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_RESP    = 2'd1;
  localparam logic [1:0] OP_SERVICE = 2'd2;

  // Link status codes
  localparam logic [1:0] LINK_BUSY   = 2'd0;
  localparam logic [1:0] LINK_READY  = 2'd1;
  localparam logic [1:0] LINK_FAILED = 2'd2;

  // Retry limits
  localparam logic [4:0] RESET_TRIES  = 5'd20;
  localparam logic [1:0] LENGTH_TRIES = 2'd3;

  localparam logic [12:0] BLOCK_SIZE_RESET = 13'd512;

  // Command tokens (index with bit 6 set)
  localparam logic [6:0] TOK_CMD0   = 7'h40;
  localparam logic [6:0] TOK_CMD1   = 7'h41;
  localparam logic [6:0] TOK_CMD8   = 7'h48;
  localparam logic [6:0] TOK_CMD13  = 7'h4D;
  localparam logic [6:0] TOK_CMD16  = 7'h50;
  localparam logic [6:0] TOK_CMD24  = 7'h58;
  localparam logic [6:0] TOK_ACMD41 = 7'h69;
  localparam logic [6:0] TOK_CMD55  = 7'h77;

  // Fixed arguments
  localparam logic [31:0] ARG_ZERO   = 32'h0000_0000;
  localparam logic [31:0] ARG_CMD8   = 32'h0000_01AA;
  localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;

  // CRC bytes
  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [7:0] CRC_CMD55  = 8'h65;
  localparam logic [7:0] CRC_ACMD41 = 8'h77;
  localparam logic [7:0] CRC_CMD1   = 8'hF9;
  localparam logic [7:0] CRC_NONE   = 8'hFF;
  localparam logic [7:0] CRC_ZERO   = 8'h00;

  // R1 answers
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_OK      = 8'h00;
  localparam logic [7:0] R1_ILLEGAL = 8'h05;

endpackage

// ----- rtl/sdsi_if.sv -----
// Channel interfaces: request items, command items and block size writes.
`timescale 1ns / 1ps

interface sdsi_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] resp_first;
  logic [7:0] resp_second;

  modport source (output valid, output op, output resp_first, output resp_second,
                  input ready);
  modport sink (input valid, input op, input resp_first, input resp_second,
                output ready);
endinterface

interface sdsi_out_if;
  logic        valid;
  logic        ready;
  logic        cmd_valid;
  logic [6:0]  cmd_byte;
  logic [31:0] cmd_arg;
  logic [7:0]  cmd_crc;
  logic        preamble;
  logic        send_block;
  logic [1:0]  link_status;

  modport source (output valid, output cmd_valid, output cmd_byte, output cmd_arg,
                  output cmd_crc, output preamble, output send_block,
                  output link_status, input ready);
  modport sink (input valid, input cmd_valid, input cmd_byte, input cmd_arg,
                input cmd_crc, input preamble, input send_block,
                input link_status, output ready);
endinterface

interface sdsi_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] block_size_bytes;

  modport source (output valid, output block_size_bytes, input ready);
  modport sink (input valid, input block_size_bytes, output ready);
endinterface

// ----- rtl/sd_spi_init_and_write_sequencer_unit.sv -----
// Top level: SD over SPI init and block write command sequencer.
`timescale 1ns / 1ps

// Channel  | Dir | Payload                                        | Note
// ---------+-----+------------------------------------------------+---------------------
// in_ch    | in  | op, resp_first, resp_second                    | start/response/service
// out_ch   | out | cmd_valid, cmd_byte, cmd_arg, cmd_crc,         | one item per input
//          |     | preamble, send_block, link_status              |
// cfg_ch   | in  | block_size_bytes                               | CMD16 argument
//
// Result path: input register, then the sequencer decode writes the result
// register and the card state together. One item per cycle sustained while
// out_ch is ready; the decode between the two registers is the only work on
// the path.
// rst_n (synchronous) clears both valid bits and the card state; block size
// returns to 512. A stalled out_ch holds its item; in_ch keeps accepting while
// the input register can move on or is empty. cfg_ch is always ready.

module sd_spi_init_and_write_sequencer_unit (
  input  logic              clk,
  input  logic              rst_n,
  sdsi_in_if.sink           in_ch,
  sdsi_out_if.source        out_ch,
  sdsi_cfg_if.sink          cfg_ch
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41,
    PH_CMD1, PH_CMD16, PH_READY, PH_FAILED, PH_CMD13
  } phase_t;

  // Input register
  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic [7:0]  s1_r1_r;
  logic [7:0]  s1_r2_r;

  // Card state
  phase_t      phase_r, phase_nxt;
  logic [4:0]  reset_tries_r, reset_tries_nxt;
  logic        old_card_r, old_card_nxt;
  logic        app_round_r, app_round_nxt;
  logic [1:0]  length_tries_r, length_tries_nxt;
  logic [31:0] block_address_r, block_address_nxt;
  logic [12:0] block_size_r;

  // Result register
  logic        out_valid_r;
  logic        out_cmd_valid_r, out_cmd_valid_nxt;
  logic [6:0]  out_cmd_byte_r, out_cmd_byte_nxt;
  logic [31:0] out_cmd_arg_r, out_cmd_arg_nxt;
  logic [7:0]  out_cmd_crc_r, out_cmd_crc_nxt;
  logic        out_preamble_r, out_preamble_nxt;
  logic        out_send_block_r, out_send_block_nxt;
  logic [1:0]  out_link_status_r, out_link_status_nxt;

  logic advance;
  logic in_fire;

  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.cmd_valid   = out_cmd_valid_r;
  assign out_ch.cmd_byte    = out_cmd_byte_r;
  assign out_ch.cmd_arg     = out_cmd_arg_r;
  assign out_ch.cmd_crc     = out_cmd_crc_r;
  assign out_ch.preamble    = out_preamble_r;
  assign out_ch.send_block  = out_send_block_r;
  assign out_ch.link_status = out_link_status_r;

  // Sequencer decode
  always_comb begin
    phase_nxt          = phase_r;
    reset_tries_nxt    = reset_tries_r;
    old_card_nxt       = old_card_r;
    app_round_nxt      = app_round_r;
    length_tries_nxt   = length_tries_r;
    block_address_nxt  = block_address_r;
    out_cmd_valid_nxt  = 1'b0;
    out_cmd_byte_nxt   = '0;
    out_cmd_arg_nxt    = sdsi_pkg::ARG_ZERO;
    out_cmd_crc_nxt    = sdsi_pkg::CRC_ZERO;
    out_preamble_nxt   = 1'b0;
    out_send_block_nxt = 1'b0;

    priority if (s1_op_r == sdsi_pkg::OP_START) begin
      // restart from the preamble whatever the phase; address kept
      reset_tries_nxt   = 5'd1;
      old_card_nxt      = 1'b0;
      app_round_nxt     = 1'b0;
      length_tries_nxt  = 2'd0;
      phase_nxt         = PH_CMD0;
      out_cmd_valid_nxt = 1'b1;
      out_cmd_byte_nxt  = sdsi_pkg::TOK_CMD0;
      out_cmd_crc_nxt   = sdsi_pkg::CRC_CMD0;
      out_preamble_nxt  = 1'b1;
    end else if (s1_op_r == sdsi_pkg::OP_RESP) begin
      unique case (phase_r)
        PH_CMD0: begin
          out_cmd_valid_nxt = 1'b1;
          if (s1_r1_r == sdsi_pkg::R1_IDLE || reset_tries_r >= sdsi_pkg::RESET_TRIES) begin
            phase_nxt        = PH_CMD8;
            out_cmd_byte_nxt = sdsi_pkg::TOK_CMD8;
            out_cmd_arg_nxt  = sdsi_pkg::ARG_CMD8;
            out_cmd_crc_nxt  = sdsi_pkg::CRC_CMD8;
          end else begin
            reset_tries_nxt  = reset_tries_r + 5'd1;
            out_cmd_byte_nxt = sdsi_pkg::TOK_CMD0;
            out_cmd_crc_nxt  = sdsi_pkg::CRC_CMD0;
          end
        end
        PH_CMD8: begin
          out_cmd_valid_nxt = 1'b1;
          if (s1_r1_r == sdsi_pkg::R1_IDLE) begin
            app_round_nxt    = 1'b0;
            phase_nxt        = PH_CMD55;
            out_cmd_byte_nxt = sdsi_pkg::TOK_CMD55;
            out_cmd_crc_nxt  = sdsi_pkg::CRC_CMD55;
          end else begin
            out_cmd_byte_nxt = sdsi_pkg::TOK_CMD8;
            out_cmd_arg_nxt  = sdsi_pkg::ARG_CMD8;
            out_cmd_crc_nxt  = sdsi_pkg::CRC_CMD8;
          end
        end
        PH_CMD55: begin
          priority if (s1_r1_r == sdsi_pkg::R1_ILLEGAL) begin
            // old card: fall back to CMD1
            old_card_nxt      = 1'b1;
            phase_nxt         = PH_CMD1;
            out_cmd_valid_nxt = 1'b1;
            out_cmd_byte_nxt  = sdsi_pkg::TOK_CMD1;
            out_cmd_crc_nxt   = sdsi_pkg::CRC_CMD1;
          end else if (s1_r1_r == sdsi_pkg::R1_IDLE) begin
            phase_nxt         = PH_ACMD41;
            out_cmd_valid_nxt = 1'b1;
            out_cmd_byte_nxt  = sdsi_pkg::TOK_ACMD41;
            out_cmd_arg_nxt   = sdsi_pkg::ARG_ACMD41;
            out_cmd_crc_nxt   = sdsi_pkg::CRC_ACMD41;
          end else begin
            phase_nxt = PH_FAILED;
          end
        end
        PH_ACMD41: begin
          priority if (!app_round_r) begin
            app_round_nxt     = 1'b1;
            phase_nxt         = PH_CMD55;
            out_cmd_valid_nxt = 1'b1;
            out_cmd_byte_nxt  = sdsi_pkg::TOK_CMD55;
            out_cmd_crc_nxt   = sdsi_pkg::CRC_CMD55;
          end else if (s1_r1_r != sdsi_pkg::R1_OK) begin
            phase_nxt = PH_FAILED;
          end else begin
            length_tries_nxt  = 2'd1;
            phase_nxt         = PH_CMD16;
            out_cmd_valid_nxt = 1'b1;
            out_cmd_byte_nxt  = sdsi_pkg::TOK_CMD16;
            out_cmd_arg_nxt   = {19'd0, block_size_r};
            out_cmd_crc_nxt   = sdsi_pkg::CRC_NONE;
          end
        end
        PH_CMD1: begin
          // answer ignored
          out_cmd_valid_nxt = 1'b1;
          if (!app_round_r) begin
            app_round_nxt    = 1'b1;
            out_cmd_byte_nxt = sdsi_pkg::TOK_CMD1;
            out_cmd_crc_nxt  = sdsi_pkg::CRC_CMD1;
          end else begin
            length_tries_nxt = 2'd1;
            phase_nxt        = PH_CMD16;
            out_cmd_byte_nxt = sdsi_pkg::TOK_CMD16;
            out_cmd_arg_nxt  = {19'd0, block_size_r};
            out_cmd_crc_nxt  = sdsi_pkg::CRC_NONE;
          end
        end
        PH_CMD16: begin
          priority if (s1_r1_r == sdsi_pkg::R1_OK) begin
            phase_nxt = PH_READY;
          end else if (length_tries_r < sdsi_pkg::LENGTH_TRIES) begin
            length_tries_nxt  = length_tries_r + 2'd1;
            out_cmd_valid_nxt = 1'b1;
            out_cmd_byte_nxt  = sdsi_pkg::TOK_CMD16;
            out_cmd_arg_nxt   = {19'd0, block_size_r};
            out_cmd_crc_nxt   = sdsi_pkg::CRC_NONE;
          end else begin
            phase_nxt = PH_FAILED;
          end
        end
        PH_CMD13: begin
          phase_nxt = PH_READY;
          // clean R2 status with R1 idle or OK: write the next block
          if (s1_r2_r == 8'h00 &&
              (s1_r1_r == sdsi_pkg::R1_IDLE || s1_r1_r == sdsi_pkg::R1_OK)) begin
            out_cmd_valid_nxt  = 1'b1;
            out_cmd_byte_nxt   = sdsi_pkg::TOK_CMD24;
            out_cmd_arg_nxt    = block_address_r;
            out_cmd_crc_nxt    = sdsi_pkg::CRC_ZERO;
            out_send_block_nxt = 1'b1;
            block_address_nxt  = block_address_r + 32'd1;
          end
        end
        default: begin
          // no command pending: ignored
        end
      endcase
    end else if (s1_op_r == sdsi_pkg::OP_SERVICE) begin
      if (phase_r == PH_READY) begin
        phase_nxt         = PH_CMD13;
        out_cmd_valid_nxt = 1'b1;
        out_cmd_byte_nxt  = sdsi_pkg::TOK_CMD13;
        out_cmd_crc_nxt   = sdsi_pkg::CRC_NONE;
      end
    end else begin
      // unused opcode: ignored
    end

    priority if (phase_nxt == PH_READY || phase_nxt == PH_CMD13) begin
      out_link_status_nxt = sdsi_pkg::LINK_READY;
    end else if (phase_nxt == PH_FAILED) begin
      out_link_status_nxt = sdsi_pkg::LINK_FAILED;
    end else begin
      out_link_status_nxt = sdsi_pkg::LINK_BUSY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      phase_r         <= PH_IDLE;
      reset_tries_r   <= '0;
      old_card_r      <= 1'b0;
      app_round_r     <= 1'b0;
      length_tries_r  <= '0;
      block_address_r <= '0;
      block_size_r    <= sdsi_pkg::BLOCK_SIZE_RESET;
    end else begin
      if (cfg_ch.valid) begin
        block_size_r <= cfg_ch.block_size_bytes;
      end
      if (in_fire) begin
        s1_op_r <= in_ch.op;
        s1_r1_r <= in_ch.resp_first;
        s1_r2_r <= in_ch.resp_second;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (advance) begin
        phase_r           <= phase_nxt;
        reset_tries_r     <= reset_tries_nxt;
        old_card_r        <= old_card_nxt;
        app_round_r       <= app_round_nxt;
        length_tries_r    <= length_tries_nxt;
        block_address_r   <= block_address_nxt;
        out_cmd_valid_r   <= out_cmd_valid_nxt;
        out_cmd_byte_r    <= out_cmd_byte_nxt;
        out_cmd_arg_r     <= out_cmd_arg_nxt;
        out_cmd_crc_r     <= out_cmd_crc_nxt;
        out_preamble_r    <= out_preamble_nxt;
        out_send_block_r  <= out_send_block_nxt;
        out_link_status_r <= out_link_status_nxt;
        out_valid_r       <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // An old card never reaches the ACMD41 phase before a restart
  a_old_card_no_acmd41: assert property (@(posedge clk) disable iff (!rst_n)
    old_card_r |-> phase_r != PH_ACMD41)
    else $error("old card in ACMD41 phase");

  a_length_tries_bound: assert property (@(posedge clk) disable iff (!rst_n)
    length_tries_r <= sdsi_pkg::LENGTH_TRIES)
    else $error("length retry count out of range");

  a_block_is_cmd24: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_send_block_r |->
      out_cmd_valid_r && out_cmd_byte_r == sdsi_pkg::TOK_CMD24 &&
      out_link_status_r == sdsi_pkg::LINK_READY)
    else $error("data block without a ready CMD24");

  a_preamble_is_cmd0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_preamble_r |->
      out_cmd_valid_r && out_cmd_byte_r == sdsi_pkg::TOK_CMD0)
    else $error("preamble without CMD0");

  a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
    advance && out_send_block_nxt |=> block_address_r == $past(block_address_r) + 32'd1)
    else $error("block address did not step");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the SD SPI init and write sequencer command stream.
`timescale 1ns / 1ps

module tb;

  // op code that the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // output hold-off used to back the block up into its input
  localparam int HOLD_CYCLES = 60;
  // two register stages plus a little slack
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_ITEMS = 170;

  // Which command is waiting for its answer
  typedef enum logic [3:0] {
    ST_IDLE, ST_CMD0, ST_CMD8, ST_CMD55, ST_ACMD41, ST_CMD1,
    ST_CMD16, ST_READY, ST_FAILED, ST_CMD13
  } seq_state_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [6:0]  cmd_byte;
    logic [31:0] cmd_arg;
    logic [7:0]  cmd_crc;
    logic        preamble;
    logic        send_block;
    logic [1:0]  link_status;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] r1;
    logic [7:0] r2;
  } req_item_t;

  // Card-side sequencer model plus the queue of command items it predicts.
  class sdsi_scoreboard;
    seq_state_t  st;
    logic [4:0]  reset_tries;
    logic        old_card;
    logic        app_round;
    logic [1:0]  length_tries;
    logic [31:0] block_addr;
    logic [12:0] block_size;
    cmd_item_t   cur;
    cmd_item_t   pending_cmds[$];
    int          failures;
    int          checked;
    int          block_writes;
    int          init_fails;

    function new();
      st           = ST_IDLE;
      reset_tries  = '0;
      old_card     = 1'b0;
      app_round    = 1'b0;
      length_tries = '0;
      block_addr   = '0;
      block_size   = sdsi_pkg::BLOCK_SIZE_RESET;
      failures     = 0;
      checked      = 0;
      block_writes = 0;
      init_fails   = 0;
    endfunction

    function void set_block_size(logic [12:0] v);
      block_size = v;
    endfunction

    function void issue(logic [6:0] tok, logic [31:0] arg, logic [7:0] crc);
      cur.cmd_valid = 1'b1;
      cur.cmd_byte  = tok;
      cur.cmd_arg   = arg;
      cur.cmd_crc   = crc;
    endfunction

    function void start_length();
      length_tries = 2'd1;
      st = ST_CMD16;
      issue(sdsi_pkg::TOK_CMD16, {19'd0, block_size}, sdsi_pkg::CRC_NONE);
    endfunction

    function void answer(logic [7:0] r1, logic [7:0] r2);
      case (st)
        ST_CMD0: begin
          if (r1 == sdsi_pkg::R1_IDLE || reset_tries >= sdsi_pkg::RESET_TRIES) begin
            st = ST_CMD8;
            issue(sdsi_pkg::TOK_CMD8, sdsi_pkg::ARG_CMD8, sdsi_pkg::CRC_CMD8);
          end else begin
            reset_tries = reset_tries + 5'd1;
            issue(sdsi_pkg::TOK_CMD0, sdsi_pkg::ARG_ZERO, sdsi_pkg::CRC_CMD0);
          end
        end
        ST_CMD8: begin
          if (r1 == sdsi_pkg::R1_IDLE) begin
            app_round = 1'b0;
            st = ST_CMD55;
            issue(sdsi_pkg::TOK_CMD55, sdsi_pkg::ARG_ZERO, sdsi_pkg::CRC_CMD55);
          end else begin
            issue(sdsi_pkg::TOK_CMD8, sdsi_pkg::ARG_CMD8, sdsi_pkg::CRC_CMD8);
          end
        end
        ST_CMD55: begin
          if (r1 == sdsi_pkg::R1_ILLEGAL) begin
            old_card = 1'b1;
            st = ST_CMD1;
            issue(sdsi_pkg::TOK_CMD1, sdsi_pkg::ARG_ZERO, sdsi_pkg::CRC_CMD1);
          end else if (r1 == sdsi_pkg::R1_IDLE) begin
            st = ST_ACMD41;
            issue(sdsi_pkg::TOK_ACMD41, sdsi_pkg::ARG_ACMD41, sdsi_pkg::CRC_ACMD41);
          end else begin
            st = ST_FAILED;
          end
        end
        ST_ACMD41: begin
          if (!app_round) begin
            app_round = 1'b1;
            st = ST_CMD55;
            issue(sdsi_pkg::TOK_CMD55, sdsi_pkg::ARG_ZERO, sdsi_pkg::CRC_CMD55);
          end else if (r1 != sdsi_pkg::R1_OK) begin
            st = ST_FAILED;
          end else begin
            start_length();
          end
        end
        ST_CMD1: begin
          if (!app_round) begin
            app_round = 1'b1;
            issue(sdsi_pkg::TOK_CMD1, sdsi_pkg::ARG_ZERO, sdsi_pkg::CRC_CMD1);
          end else begin
            start_length();
          end
        end
        ST_CMD16: begin
          if (r1 == sdsi_pkg::R1_OK) begin
            st = ST_READY;
          end else if (length_tries < sdsi_pkg::LENGTH_TRIES) begin
            length_tries = length_tries + 2'd1;
            issue(sdsi_pkg::TOK_CMD16, {19'd0, block_size}, sdsi_pkg::CRC_NONE);
          end else begin
            st = ST_FAILED;
          end
        end
        ST_CMD13: begin
          st = ST_READY;
          if (r2 == 8'h00 && (r1 == sdsi_pkg::R1_IDLE || r1 == sdsi_pkg::R1_OK)) begin
            issue(sdsi_pkg::TOK_CMD24, block_addr, sdsi_pkg::CRC_ZERO);
            cur.send_block = 1'b1;
            block_addr = block_addr + 32'd1;
            block_writes++;
          end
        end
        default: ;
      endcase
    endfunction

    // Returns 1 when the item did something (issued a frame or moved the state).
    function bit note_request(logic [1:0] op, logic [7:0] r1, logic [7:0] r2);
      seq_state_t prev;
      prev = st;
      cur = '0;
      case (op)
        sdsi_pkg::OP_START: begin
          reset_tries  = 5'd1;
          old_card     = 1'b0;
          app_round    = 1'b0;
          length_tries = 2'd0;
          st = ST_CMD0;
          issue(sdsi_pkg::TOK_CMD0, sdsi_pkg::ARG_ZERO, sdsi_pkg::CRC_CMD0);
          cur.preamble = 1'b1;
        end
        sdsi_pkg::OP_RESP: answer(r1, r2);
        sdsi_pkg::OP_SERVICE: begin
          if (st == ST_READY) begin
            st = ST_CMD13;
            issue(sdsi_pkg::TOK_CMD13, sdsi_pkg::ARG_ZERO, sdsi_pkg::CRC_NONE);
          end
        end
        default: ;
      endcase
      if (st == ST_READY || st == ST_CMD13) cur.link_status = sdsi_pkg::LINK_READY;
      else if (st == ST_FAILED) cur.link_status = sdsi_pkg::LINK_FAILED;
      else cur.link_status = sdsi_pkg::LINK_BUSY;
      if (st == ST_FAILED && prev != ST_FAILED) init_fails++;
      pending_cmds.push_back(cur);
      return cur.cmd_valid || (st != prev);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_cmd(cmd_item_t got);
      cmd_item_t want;
      if (pending_cmds.size() == 0) begin
        $error("command item arrived with nothing expected");
        failures++;
        return;
      end
      want = pending_cmds.pop_front();
      checked++;
      compare("cmd_valid", 32'(want.cmd_valid), 32'(got.cmd_valid));
      compare("cmd_byte", 32'(want.cmd_byte), 32'(got.cmd_byte));
      compare("cmd_arg", want.cmd_arg, got.cmd_arg);
      compare("cmd_crc", 32'(want.cmd_crc), 32'(got.cmd_crc));
      compare("preamble", 32'(want.preamble), 32'(got.preamble));
      compare("send_block", 32'(want.send_block), 32'(got.send_block));
      compare("link_status", 32'(want.link_status), 32'(got.link_status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sdsi_in_if  in_ch ();
  sdsi_out_if out_ch ();
  sdsi_cfg_if cfg_ch ();

  sd_spi_init_and_write_sequencer_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  sdsi_scoreboard sb;

  // idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_req       = 1'b0;  // one-shot long output hold-off
  bit stubborn       = 1'b0;  // steered CMD0 answers for the current card are never idle
  int n_req          = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("[sd_spi_init_and_write_sequencer_unit] ERROR");
    $finish;
  end

  // Offer one request item, with random idle cycles first; waits for accept.
  task automatic send_request(input req_item_t rq, output bit acted);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= rq.op;
    in_ch.resp_first  <= rq.r1;
    in_ch.resp_second <= rq.r2;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    n_req++;
    acted = sb.note_request(rq.op, rq.r1, rq.r2);
  endtask

  // Block size write; only ever called with the block drained.
  task automatic write_block_size(input logic [12:0] v);
    cfg_ch.valid            <= 1'b1;
    cfg_ch.block_size_bytes <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.set_block_size(v);
  endtask

  // Wait for every predicted item, then let the pipeline settle.
  task automatic drain();
    while (sb.pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed card answers steered by the model state, plus noise.
  task automatic run_random(input int n_items);
    int        done;
    int        pick;
    bit        acted;
    req_item_t rq;
    done = 0;
    while (done < n_items) begin
      rq.r1 = 8'($urandom_range(255));
      rq.r2 = 8'($urandom_range(255));
      pick  = $urandom_range(99);
      if ($urandom_range(99) < 12) begin
        rq.op = 2'($urandom_range(3));
      end else begin
        rq.op = sdsi_pkg::OP_RESP;
        case (sb.st)
          ST_IDLE, ST_FAILED: rq.op = sdsi_pkg::OP_START;
          ST_CMD0: begin
            if (stubborn) begin
              if (rq.r1 == sdsi_pkg::R1_IDLE) rq.r1 = 8'hFE;
            end else if (pick < 60) begin
              rq.r1 = sdsi_pkg::R1_IDLE;
            end
          end
          ST_CMD8: if (pick < 65) rq.r1 = sdsi_pkg::R1_IDLE;
          ST_CMD55: begin
            if (pick < 75) rq.r1 = sdsi_pkg::R1_IDLE;
            else if (pick < 95) rq.r1 = sdsi_pkg::R1_ILLEGAL;
          end
          ST_ACMD41: if (sb.app_round && pick < 85) rq.r1 = sdsi_pkg::R1_OK;
          ST_CMD16: if (pick < 70) rq.r1 = sdsi_pkg::R1_OK;
          ST_READY: begin
            if (pick < 77) rq.op = sdsi_pkg::OP_SERVICE;
            else if (pick >= 92) rq.op = sdsi_pkg::OP_START;
          end
          ST_CMD13: begin
            if (pick < 75) begin
              rq.r2 = 8'h00;
              rq.r1 = $urandom_range(1) ? sdsi_pkg::R1_IDLE : sdsi_pkg::R1_OK;
            end
          end
          default: ;  // CMD1 answers do not matter
        endcase
      end
      if (rq.op == sdsi_pkg::OP_START) stubborn = ($urandom_range(9) == 0);
      send_request(rq, acted);
      if (acted) done++;
    end
    in_ch.valid <= 1'b0;
  endtask

  // Result side: random back-pressure, plus the one long hold-off.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every accepted result item goes against the oldest prediction.
  always @(posedge clk) begin : result_monitor
    cmd_item_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.cmd_valid   = out_ch.cmd_valid;
      got.cmd_byte    = out_ch.cmd_byte;
      got.cmd_arg     = out_ch.cmd_arg;
      got.cmd_crc     = out_ch.cmd_crc;
      got.preamble    = out_ch.preamble;
      got.send_block  = out_ch.send_block;
      got.link_status = out_ch.link_status;
      sb.check_cmd(got);
    end
  end

  // Directed walk: ignored items at reset, full new-card init with retries,
  // writes and a bad status, restart while ready, old card with CMD16 running
  // out of tries, then an unexpected CMD55 answer.
  req_item_t directed [] = '{
    '{sdsi_pkg::OP_RESP,    8'hFF, 8'hFF},  // answer with nothing pending
    '{sdsi_pkg::OP_SERVICE, 8'h00, 8'h00},  // service before ready
    '{OP_UNUSED,            8'hAA, 8'h55},
    '{sdsi_pkg::OP_START,   8'h00, 8'h00},
    '{sdsi_pkg::OP_RESP,    8'h00, 8'h00},  // CMD0 not idle, retry
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'h00},
    '{sdsi_pkg::OP_RESP,    8'hFF, 8'h00},  // CMD8 repeats
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'h00},
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'h00},  // CMD55 ok, ACMD41
    '{sdsi_pkg::OP_RESP,    8'hFF, 8'hFF},    // first ACMD41 answer ignored
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'h00},
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_OK, 8'h00},    // CMD16 next
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'h00},  // CMD16 retry
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_OK, 8'h00},    // ready
    '{sdsi_pkg::OP_SERVICE, 8'h00, 8'h00},
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_OK, 8'h00},    // all-zero status, write
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_OK, 8'h00},    // write answer ignored
    '{sdsi_pkg::OP_SERVICE, 8'h00, 8'h00},
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'h00},  // idle status, write
    '{sdsi_pkg::OP_SERVICE, 8'h00, 8'h00},
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'hFF},  // bad status, no write
    '{sdsi_pkg::OP_START,   8'hFF, 8'hFF},    // restart while ready
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'h00},
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'h00},
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_ILLEGAL, 8'h00},  // old card
    '{sdsi_pkg::OP_RESP,    8'hFF, 8'h00},
    '{sdsi_pkg::OP_RESP,    8'hFF, 8'h00},
    '{sdsi_pkg::OP_RESP,    8'hFF, 8'h00},    // CMD16 fails three times
    '{sdsi_pkg::OP_RESP,    8'hFF, 8'h00},
    '{sdsi_pkg::OP_RESP,    8'hFF, 8'h00},
    '{sdsi_pkg::OP_START,   8'h00, 8'h00},
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'h00},
    '{sdsi_pkg::OP_RESP,    sdsi_pkg::R1_IDLE, 8'h00},
    '{sdsi_pkg::OP_RESP,    8'h33, 8'h00}     // unexpected CMD55 answer
  };

  initial begin : stimulus
    bit acted;
    sb = new();
    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.op                <= sdsi_pkg::OP_START;
    in_ch.resp_first        <= 8'h00;
    in_ch.resp_second       <= 8'h00;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.block_size_bytes <= sdsi_pkg::BLOCK_SIZE_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset block size
    foreach (directed[i]) send_request(directed[i], acted);
    in_ch.valid <= 1'b0;
    drain();

    // no idling, with the long hold-off to fill the pipeline
    write_block_size(13'd1);
    hold_req = 1'b1;
    run_random(PHASE_ITEMS);
    drain();

    write_block_size(13'd4096);
    send_idle_pct = 68;
    run_random(PHASE_ITEMS);
    drain();

    // out-of-range sizes pass through untouched
    write_block_size(13'd0);
    send_idle_pct  = 0;
    recv_stall_pct = 68;
    run_random(PHASE_ITEMS);
    drain();

    write_block_size(13'h1FFF);
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    run_random(PHASE_ITEMS);
    drain();

    write_block_size(13'($urandom_range(1, 4096)));
    send_idle_pct  = 30;
    recv_stall_pct = 40;
    run_random(PHASE_ITEMS);
    drain();

    $display("Covered %0d request items, %0d command items checked,", n_req, sb.checked);
    $display("%0d block writes, %0d failed inits.", sb.block_writes, sb.init_fails);
    $display("Block sizes reset, 1, 4096, 0, 8191 and random; idle, sender, receiver, mixed stalls.");
    if (sb.failures == 0) begin
      $display("[sd_spi_init_and_write_sequencer_unit] OK");
    end else begin
      $display("[sd_spi_init_and_write_sequencer_unit] ERROR");
    end
    $finish;
  end

endmodule
